>>> rtl/kvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants of the key/value text tokenizer
// Byte classes, escape decoding, event and cause codes, queue sizing.
// ----------------------------------------------------------------------------
package kvt_pkg;

   localparam int MAX_DEPTH = 256;
   localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - 8 - DEPTH_W - 3;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef enum logic [2:0] {
      EV_KEY_CHAR = 3'd0,
      EV_KEY_END  = 3'd1,
      EV_VAL_CHAR = 3'd2,
      EV_PAIR_END = 3'd3,
      EV_OPEN     = 3'd4,
      EV_CLOSE    = 3'd5,
      EV_DONE     = 3'd6,
      EV_ERROR    = 3'd7
   } kvt_event_type;

   typedef enum logic [2:0] {
      CAUSE_NONE   = 3'd0,
      CAUSE_ESCAPE = 3'd1,
      CAUSE_CHAR   = 3'd2,
      CAUSE_DEPTH  = 3'd3,
      CAUSE_END    = 3'd4
   } kvt_cause_type;

   typedef enum logic [5:0] {
      MODE_EXPECT    = 6'b000001,
      MODE_NAME      = 6'b000010,
      MODE_NAME_ESC  = 6'b000100,
      MODE_AFTER     = 6'b001000,
      MODE_VALUE     = 6'b010000,
      MODE_VALUE_ESC = 6'b100000
   } kvt_mode_type;

   // One classified byte as it travels from the front end to the back end.
   typedef struct packed {
      logic       eob;
      logic       blank;
      logic       quote;
      logic       lbrace;
      logic       rbrace;
      logic       bslash;
      logic       esc_ok;
      logic [7:0] esc_char;
      logic [7:0] raw;
   } kvt_item_type;

   // Escape table: bit 8 marks a supported escape, bits 7:0 give its value.
   function automatic logic [8:0] kvt_decode_escape(input logic [7:0] c);
      logic [8:0] r;
      begin
         unique case (c)
            8'h27:   r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            8'h3F:   r = {1'b1, 8'h3F};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h61:   r = {1'b1, 8'h07};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            8'h76:   r = {1'b1, 8'h0B};
            default: r = {1'b0, 8'h00};
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

>>> rtl/kvt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_front: input acceptance and byte classification
// Take a transfer while the queue has room and tag the byte with its classes.
// ----------------------------------------------------------------------------
module kvt_front
   import kvt_pkg::*;
(
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] text_byte
   input  wire logic         req_tuser,   // [0] action
   input  wire logic         q_ready,
   output logic              q_push,
   output kvt_item_type      q_item
);

   logic [8:0] esc;

   assign esc        = kvt_decode_escape(req_tdata);
   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   always_comb begin
      q_item.eob      = req_tuser || (req_tdata == CH_NUL);
      q_item.blank    = (req_tdata == CH_SPACE) ||
                        ((req_tdata >= CH_TAB) && (req_tdata <= CH_CR));
      q_item.quote    = (req_tdata == CH_QUOTE);
      q_item.lbrace   = (req_tdata == CH_LBRACE);
      q_item.rbrace   = (req_tdata == CH_RBRACE);
      q_item.bslash   = (req_tdata == CH_BSLASH);
      q_item.esc_ok   = esc[8];
      q_item.esc_char = esc[7:0];
      q_item.raw      = req_tdata;
   end

endmodule
`default_nettype wire

>>> rtl/kvt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_queue: short item queue between front and back end
// Register classified bytes so that either side can stall on its own.
// ----------------------------------------------------------------------------
module kvt_queue
   import kvt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire kvt_item_type push_item,
   output logic              ready,
   input  wire logic         pop,
   output logic              valid,
   output kvt_item_type      head_item
);

   kvt_item_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         count_ff, count_in;

   assign ready     = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

>>> rtl/kvt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_back: tokenizer state machine and result register
// Advance the parse mode, nesting depth and sticky error for each byte.
// ----------------------------------------------------------------------------
module kvt_back
   import kvt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   output logic                        q_pop,
   input  wire kvt_item_type           q_item,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,  // [7:0] decoded_char,
                                                   // [16:8] nest_depth,
                                                   // [19:17] error_cause
   output logic [2:0]                  rsp_tuser   // [2:0] event_kind
);

   kvt_mode_type          mode_ff, mode_in;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   logic                  failed_ff, failed_in;
   kvt_cause_type         cause_ff, cause_in;

   logic                  out_valid_ff, out_valid_in;
   kvt_event_type         kind_ff;
   logic [7:0]            char_ff;
   logic [DEPTH_W-1:0]    out_depth_ff;
   kvt_cause_type         out_cause_ff;

   logic                  emit;
   kvt_event_type         ev_kind;
   logic [7:0]            ev_char;
   logic [DEPTH_W-1:0]    ev_depth;
   kvt_cause_type         ev_cause;

   // Take the next byte whenever the result register is free or draining.
   assign q_pop = q_valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      mode_in   = mode_ff;
      depth_in  = depth_ff;
      failed_in = failed_ff;
      cause_in  = cause_ff;
      emit      = 1'b0;
      ev_kind   = EV_DONE;
      ev_char   = 8'h00;
      ev_depth  = depth_ff;
      ev_cause  = CAUSE_NONE;

      if (q_pop) begin
         if (q_item.eob) begin
            emit = 1'b1;
            priority if (failed_ff) begin
               ev_kind  = EV_ERROR;
               ev_cause = cause_ff;
            end else if (mode_ff != MODE_EXPECT) begin
               ev_kind  = EV_ERROR;
               ev_cause = CAUSE_END;
            end else begin
               ev_kind  = EV_DONE;
            end
            mode_in   = MODE_EXPECT;
            depth_in  = '0;
            failed_in = 1'b0;
            cause_in  = CAUSE_NONE;
         end else if (!failed_ff) begin
            unique case (mode_ff)
               MODE_NAME, MODE_VALUE: begin
                  if (q_item.bslash) begin
                     mode_in = (mode_ff == MODE_NAME) ? MODE_NAME_ESC : MODE_VALUE_ESC;
                  end else if (q_item.quote) begin
                     emit = 1'b1;
                     if (mode_ff == MODE_NAME) begin
                        mode_in = MODE_AFTER;
                        ev_kind = EV_KEY_END;
                     end else begin
                        mode_in = MODE_EXPECT;
                        ev_kind = EV_PAIR_END;
                     end
                  end else begin
                     emit    = 1'b1;
                     ev_kind = (mode_ff == MODE_NAME) ? EV_KEY_CHAR : EV_VAL_CHAR;
                     ev_char = q_item.raw;
                  end
               end
               MODE_NAME_ESC, MODE_VALUE_ESC: begin
                  emit = 1'b1;
                  if (q_item.esc_ok) begin
                     ev_char = q_item.esc_char;
                     if (mode_ff == MODE_NAME_ESC) begin
                        mode_in = MODE_NAME;
                        ev_kind = EV_KEY_CHAR;
                     end else begin
                        mode_in = MODE_VALUE;
                        ev_kind = EV_VAL_CHAR;
                     end
                  end else begin
                     failed_in = 1'b1;
                     cause_in  = CAUSE_ESCAPE;
                     ev_kind   = EV_ERROR;
                     ev_cause  = CAUSE_ESCAPE;
                  end
               end
               MODE_AFTER: begin
                  priority if (q_item.blank) begin
                     mode_in = MODE_AFTER;
                  end else if (q_item.quote) begin
                     mode_in = MODE_VALUE;
                  end else if (q_item.lbrace && (depth_ff < DEPTH_W'(MAX_DEPTH))) begin
                     emit     = 1'b1;
                     depth_in = depth_ff + DEPTH_W'(1);
                     mode_in  = MODE_EXPECT;
                     ev_kind  = EV_OPEN;
                     ev_depth = depth_ff + DEPTH_W'(1);
                  end else begin
                     emit      = 1'b1;
                     failed_in = 1'b1;
                     cause_in  = q_item.lbrace ? CAUSE_DEPTH : CAUSE_CHAR;
                     ev_kind   = EV_ERROR;
                     ev_cause  = q_item.lbrace ? CAUSE_DEPTH : CAUSE_CHAR;
                  end
               end
               default: begin
                  // Expect name: skip blanks, open a name, close a node, or flag any other byte.
                  mode_in = MODE_EXPECT;
                  priority if (q_item.blank) begin
                     mode_in = MODE_EXPECT;
                  end else if (q_item.quote) begin
                     mode_in = MODE_NAME;
                  end else if (q_item.rbrace && (depth_ff != '0)) begin
                     emit     = 1'b1;
                     depth_in = depth_ff - DEPTH_W'(1);
                     ev_kind  = EV_CLOSE;
                     ev_depth = depth_ff - DEPTH_W'(1);
                  end else begin
                     emit      = 1'b1;
                     failed_in = 1'b1;
                     cause_in  = CAUSE_CHAR;
                     ev_kind   = EV_ERROR;
                     ev_cause  = CAUSE_CHAR;
                  end
               end
            endcase
         end
      end

      priority if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_EXPECT;
         depth_ff     <= '0;
         failed_ff    <= 1'b0;
         cause_ff     <= CAUSE_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         depth_ff     <= depth_in;
         failed_ff    <= failed_in;
         cause_ff     <= cause_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff      <= ev_kind;
         char_ff      <= ev_char;
         out_depth_ff <= ev_depth;
         out_cause_ff <= ev_cause;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_cause_ff, out_depth_ff, char_ff};

endmodule
`default_nettype wire

>>> rtl/keyvalue_text_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyvalue_text_tokenizer: streaming tokenizer for nested quoted key/value text
// Turns a byte stream into key, value, node and outcome events.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock while req_tready is high and
// gives at most one event per byte: key and value characters with escapes
// resolved, key end, pair end, node open and close with the new nesting
// depth, and on end of buffer (tuser high or a zero byte) either done or an
// error with its cause. The first error is reported at once; later data
// bytes are dropped until end of buffer, which repeats the error and
// restarts the tokenizer. Sustained rate is one byte per cycle while
// rsp_tready stays high, set by the state update in the back end; a byte
// passes the four-entry queue and then the result register before its
// event is presented. Silent bytes (blanks, opening quotes, backslashes)
// still take their turn in the back end. The queue lets req_tready stay
// high for up to four transfers while a result waits on rsp_tready.
// ----------------------------------------------------------------------------
module keyvalue_text_tokenizer
   import kvt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] text_byte
   input  wire logic                   req_tuser,   // [0] action
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [7:0] decoded_char,
                                                    // [16:8] nest_depth,
                                                    // [19:17] error_cause
   output logic [2:0]                  rsp_tuser    // [2:0] event_kind
);

   // Classified byte entering the queue and the one leaving it.
   kvt_item_type  push_item;
   kvt_item_type  head_item;
   logic          q_ready;
   logic          q_push;
   logic          q_valid;
   logic          q_pop;

   // Front end: accept the transfer and classify the byte.
   kvt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   // Decoupling queue: hold classified bytes while the back end stalls.
   kvt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .head_item (head_item)
   );

   // Back end: advance the tokenizer and register the event.
   kvt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (head_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // A cause is carried only by an error event.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != EV_ERROR)) |-> (rsp_tdata[19:17] == CAUSE_NONE))
      else $error("cause on a non-error event");

   // Opening a node always leaves a nonzero depth within the limit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == EV_OPEN)) |->
         ((rsp_tdata[16:8] != '0) && (rsp_tdata[16:8] <= DEPTH_W'(MAX_DEPTH))))
      else $error("node open with bad depth");

   // Only key and value characters carry a character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != EV_KEY_CHAR) && (rsp_tuser != EV_VAL_CHAR)) |->
         (rsp_tdata[7:0] == 8'h00))
      else $error("character on a non-character event");

   // No result is presented right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule
`default_nettype wire
